// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define DHG_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the same cycle as its antecedent
`define DHG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/dhg_pkg.sv -----
package dhg_pkg;

    localparam int IN_FRAC_BITS  = 14;
    localparam int OUT_FRAC_BITS = 20;
    localparam int DIR_W         = 16;
    localparam int WEIGHT_W      = 15;
    localparam int PHASE_W       = 32;

    // lobe datapath widths
    localparam int NUM_W    = 2 * IN_FRAC_BITS + 1;
    localparam int DEN_W    = 2 * IN_FRAC_BITS + 2;
    localparam int DN_W     = 32;
    localparam int SN_W     = 31;
    localparam int SQ_STEPS = SN_W;
    localparam int SQ_REM_W = 33;
    localparam int K_W      = 29;
    localparam int PROD_W   = 57;
    localparam int E_MAX    = 62;
    localparam int NFULL_W  = PROD_W + E_MAX;
    localparam int LOBE_W   = 59;
    localparam int DIV_W    = 63;
    localparam int E_BIAS   = IN_FRAC_BITS + OUT_FRAC_BITS - 17;

    localparam logic [K_W-1:0] INV_FOUR_PI_Q32 = 29'd341782638;

    typedef struct packed {
        logic signed [DIR_W-1:0] incoming_x;
        logic signed [DIR_W-1:0] incoming_y;
        logic signed [DIR_W-1:0] incoming_z;
        logic signed [DIR_W-1:0] outgoing_x;
        logic signed [DIR_W-1:0] outgoing_y;
        logic signed [DIR_W-1:0] outgoing_z;
    } t_dir_in;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_value;
        logic               saturated;
    } t_phase_out;

    typedef enum logic [1:0] {
        CFG_LOBE_A_ASYM   = 2'd0,
        CFG_LOBE_B_ASYM   = 2'd1,
        CFG_LOBE_A_WEIGHT = 2'd2
    } t_cfg_idx;

endpackage

// ----- design/dhg_lobe.sv -----
module dhg_lobe
    import dhg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [DIR_W-1:0] i_asym,
    input  logic signed [DIR_W-1:0] i_cos,
    output logic                    o_valid,
    output logic [LOBE_W-1:0]       o_value
);

    localparam logic signed [DIR_W-1:0] G_MAX  = 16'sd16384;
    localparam logic [NUM_W-1:0]        ONE_SQ = NUM_W'(1) << (2 * IN_FRAC_BITS);

    // stage 1: clamp asymmetry
    logic                    r_v1;
    logic signed [DIR_W-1:0] r_g1, r_c1;
    logic signed [DIR_W-1:0] n_g1;

    always_comb begin
        if (i_asym > G_MAX) begin
            n_g1 = G_MAX;
        end else if (i_asym < -G_MAX) begin
            n_g1 = -G_MAX;
        end else begin
            n_g1 = i_asym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_g1 <= n_g1;
        r_c1 <= i_cos;
    end

    // stage 2: g*g and g*c
    logic                   r_v2;
    logic [NUM_W-1:0]       r_gg2;
    logic signed [29:0]     r_gc2;
    logic signed [31:0]     s_gg, s_gc;

    assign s_gg = r_g1 * r_g1;
    assign s_gc = r_g1 * r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_gg2 <= s_gg[NUM_W-1:0];
        r_gc2 <= s_gc[29:0];
    end

    // stage 3: numerator and denominator
    logic                 r_v3, r_z3;
    logic [NUM_W-1:0]     r_n3;
    logic [DEN_W-1:0]     r_d3;
    logic [NUM_W-1:0]     s_n3;
    logic [31:0]          s_gc_ext, s_d3;

    assign s_n3     = ONE_SQ - r_gg2;
    assign s_gc_ext = {{2{r_gc2[29]}}, r_gc2};
    assign s_d3     = {3'b000, ONE_SQ} + {3'b000, r_gg2} - {s_gc_ext[30:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_n3 <= s_n3;
        r_z3 <= (s_n3 == '0);
        r_d3 <= (s_n3 == '0) ? DEN_W'(1) : s_d3[DEN_W-1:0];
    end

    // stage 4: leading one and even normalizing shift
    logic             r_v4, r_z4;
    logic [NUM_W-1:0] r_n4;
    logic [DEN_W-1:0] r_d4;
    logic [4:0]       r_sh4;
    logic [5:0]       s_len, s_sh;

    always_comb begin
        s_len = '0;
        for (int i = 0; i < DEN_W; i++) begin
            if (r_d3[i]) begin
                s_len = 6'(i + 1);
            end
        end
        s_sh = 6'd32 - s_len - {5'b0, s_len[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_n4  <= r_n3;
        r_z4  <= r_z3;
        r_d4  <= r_d3;
        r_sh4 <= s_sh[4:0];
    end

    // stage 5: shift denominator, numerator times 1/(4 pi); feeds root pipeline
    logic                r_sq_v   [0:SQ_STEPS];
    logic                r_sq_z   [0:SQ_STEPS];
    logic [DN_W-1:0]     r_sq_dn  [0:SQ_STEPS];
    logic [4:0]          r_sq_sh  [0:SQ_STEPS];
    logic [PROD_W-1:0]   r_sq_p   [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] r_sq_rem [0:SQ_STEPS];
    logic [SN_W-1:0]     r_sq_rt  [0:SQ_STEPS];
    logic [NUM_W+K_W-1:0] s_p5;

    assign s_p5 = r_n4 * INV_FOUR_PI_Q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r_v4;
        end
        r_sq_z[0]   <= r_z4;
        r_sq_dn[0]  <= {{(DN_W-DEN_W){1'b0}}, r_d4} << r_sh4;
        r_sq_sh[0]  <= r_sh4;
        r_sq_p[0]   <= s_p5[PROD_W-1:0];
        r_sq_rem[0] <= '0;
        r_sq_rt[0]  <= '0;
    end

    // square root of dn * 2^30, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [61:0]         s_v;
        logic [1:0]          s_pair;
        logic [SQ_REM_W+1:0] s_acc, s_trial;
        logic                s_ge;

        assign s_v     = {r_sq_dn[k], 30'b0};
        assign s_pair  = s_v[61-2*k -: 2];
        assign s_acc   = {r_sq_rem[k], s_pair};
        assign s_trial = {2'b00, r_sq_rt[k], 2'b01};
        assign s_ge    = (s_acc >= s_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_sq_z[k+1]   <= r_sq_z[k];
            r_sq_dn[k+1]  <= r_sq_dn[k];
            r_sq_sh[k+1]  <= r_sq_sh[k];
            r_sq_p[k+1]   <= r_sq_p[k];
            r_sq_rem[k+1] <= s_ge ? SQ_REM_W'(s_acc - s_trial) : s_acc[SQ_REM_W-1:0];
            r_sq_rt[k+1]  <= {r_sq_rt[k][SN_W-2:0], s_ge};
        end
    end

    // divisor dn*sn and shifted dividend
    logic                r_dv_v   [0:LOBE_W];
    logic                r_dv_z   [0:LOBE_W];
    logic [DIV_W-1:0]    r_dv_d   [0:LOBE_W];
    logic [DIV_W-1:0]    r_dv_rem [0:LOBE_W];
    logic [LOBE_W-1:0]   r_dv_lq  [0:LOBE_W];
    logic [DN_W+SN_W-1:0] s_dsn;
    logic [5:0]          s_half, s_e;
    logic [NFULL_W-1:0]  s_nfull;

    assign s_dsn   = r_sq_dn[SQ_STEPS] * r_sq_rt[SQ_STEPS];
    assign s_half  = {2'b00, r_sq_sh[SQ_STEPS][4:1]};
    assign s_e     = 6'(E_BIAS) + s_half + {s_half[4:0], 1'b0};
    assign s_nfull = {{(NFULL_W-PROD_W){1'b0}}, r_sq_p[SQ_STEPS]} << s_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
        end
        r_dv_z[0]   <= r_sq_z[SQ_STEPS];
        r_dv_d[0]   <= s_dsn[DIV_W-1:0];
        r_dv_rem[0] <= {{(DIV_W-(NFULL_W-LOBE_W)){1'b0}}, s_nfull[NFULL_W-1:LOBE_W]};
        r_dv_lq[0]  <= s_nfull[LOBE_W-1:0];
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < LOBE_W; k++) begin : g_div
        logic [DIV_W:0] s_t, s_dd;
        logic           s_ge;

        assign s_t  = {r_dv_rem[k], r_dv_lq[k][LOBE_W-1]};
        assign s_dd = {1'b0, r_dv_d[k]};
        assign s_ge = (s_t >= s_dd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_dv_z[k+1]   <= r_dv_z[k];
            r_dv_d[k+1]   <= r_dv_d[k];
            r_dv_rem[k+1] <= s_ge ? DIV_W'(s_t - s_dd) : s_t[DIV_W-1:0];
            r_dv_lq[k+1]  <= {r_dv_lq[k][LOBE_W-2:0], s_ge};
        end
    end

    // output: pole of the lobe gives zero
    logic              r_vo;
    logic [LOBE_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_dv_v[LOBE_W];
        end
        r_val <= r_dv_z[LOBE_W] ? '0 : r_dv_lq[LOBE_W];
    end

    assign o_valid = r_vo;
    assign o_value = r_val;

endmodule

// ----- design/double_henyey_greenstein_phase.sv -----
// Double Henyey-Greenstein phase function, fully pipelined.
// Input: a pair of Q1.14 direction vectors in i_data, transferred at a rising
// edge with i_start high and o_busy low. o_busy is always low, so one pair
// can be transferred every clock cycle.
// Output: o_res (phase_value in unsigned Q12.20, saturated flag) is shown for
// exactly one cycle with o_res_valid high, in transfer order. Throughput is
// one result per cycle.
// The latency is set by the per-lobe square root (one bit per stage, 31 stages)
// and the restoring divider (one quotient bit per stage, 59 stages).
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Index 0 and 1 set the lobe asymmetries,
// index 2 the first lobe weight; other indexes are ignored. Write only while
// no item is in flight.
// Reset (synchronous, active low) empties the pipeline and sets both
// asymmetries to zero and the weight to one.
// The receiver cannot stall; each result must be taken in its strobe cycle.
`include "assert_macros.svh"

module double_henyey_greenstein_phase
    import dhg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_dir_in     i_data,
    output logic        o_res_valid,
    output t_phase_out  o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(1) << IN_FRAC_BITS;
    localparam logic signed [33:0]  DOT_MAX = 34'sd1 <<< (2 * IN_FRAC_BITS);

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic signed [DIR_W-1:0] r_asym_a, r_asym_b;
    logic [WEIGHT_W-1:0]     r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asym_a <= '0;
            r_asym_b <= '0;
            r_weight <= W_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOBE_A_ASYM:   r_asym_a <= i_cfg_data;
                CFG_LOBE_B_ASYM:   r_asym_b <= i_cfg_data;
                CFG_LOBE_A_WEIGHT: r_weight <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: component products
    logic               r_v_d1;
    logic signed [31:0] r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_d1 <= 1'b0;
        end else begin
            r_v_d1 <= i_start && !o_busy;
        end
        r_px <= i_data.incoming_x * i_data.outgoing_x;
        r_py <= i_data.incoming_y * i_data.outgoing_y;
        r_pz <= i_data.incoming_z * i_data.outgoing_z;
    end

    // stage 2: sum, clamp, round to Q1.14
    logic                    r_v_c2;
    logic signed [DIR_W-1:0] r_c2;
    logic signed [33:0]      s_dot, s_dotc, s_round;

    always_comb begin
        s_dot = 34'(r_px) + 34'(r_py) + 34'(r_pz);
        if (s_dot > DOT_MAX) begin
            s_dotc = DOT_MAX;
        end else if (s_dot < -DOT_MAX) begin
            s_dotc = -DOT_MAX;
        end else begin
            s_dotc = s_dot;
        end
        s_round = ((s_dotc + DOT_MAX + (34'sd1 <<< (IN_FRAC_BITS - 1))) >>> IN_FRAC_BITS)
                - (34'sd1 <<< IN_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c2 <= 1'b0;
        end else begin
            r_v_c2 <= r_v_d1;
        end
        r_c2 <= s_round[DIR_W-1:0];
    end

    // the two lobes
    logic              s_lv_a, s_lv_b;
    logic [LOBE_W-1:0] s_q_a, s_q_b;

    dhg_lobe u_lobe_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v_c2),
        .i_asym  (r_asym_a),
        .i_cos   (r_c2),
        .o_valid (s_lv_a),
        .o_value (s_q_a)
    );

    dhg_lobe u_lobe_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v_c2),
        .i_asym  (r_asym_b),
        .i_cos   (r_c2),
        .o_valid (s_lv_b),
        .o_value (s_q_b)
    );

    // blend stage 1: partial products
    localparam int LO_W = 30;
    localparam int HI_W = LOBE_W - LO_W;

    logic                       r_vb1;
    logic [LO_W+WEIGHT_W-1:0]   r_m1lo, r_m2lo;
    logic [HI_W+WEIGHT_W-1:0]   r_m1hi, r_m2hi;
    logic [WEIGHT_W-1:0]        s_w, s_wb;

    assign s_w  = (r_weight > W_ONE) ? W_ONE : r_weight;
    assign s_wb = W_ONE - s_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb1 <= 1'b0;
        end else begin
            r_vb1 <= s_lv_a;
        end
        r_m1lo <= s_q_a[LO_W-1:0] * s_w;
        r_m1hi <= s_q_a[LOBE_W-1:LO_W] * s_w;
        r_m2lo <= s_q_b[LO_W-1:0] * s_wb;
        r_m2hi <= s_q_b[LOBE_W-1:LO_W] * s_wb;
    end

    // blend stage 2: sum and round
    localparam int ACC_W = LOBE_W + IN_FRAC_BITS + 1;
    localparam int RES_W = ACC_W - IN_FRAC_BITS;

    logic             r_vb2;
    logic [RES_W-1:0] r_res;
    logic [ACC_W-1:0] s_acc;

    assign s_acc = ((ACC_W'(r_m1hi) + ACC_W'(r_m2hi)) << LO_W)
                 + ACC_W'(r_m1lo) + ACC_W'(r_m2lo)
                 + (ACC_W'(1) << (IN_FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb2 <= 1'b0;
        end else begin
            r_vb2 <= r_vb1;
        end
        r_res <= s_acc[ACC_W-1:IN_FRAC_BITS];
    end

    // output stage: saturation
    logic       r_out_valid;
    t_phase_out r_out;
    logic       s_sat;

    assign s_sat = |r_res[RES_W-1:PHASE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_vb2;
        end
        r_out.phase_value <= s_sat ? '1 : r_res[PHASE_W-1:0];
        r_out.saturated   <= s_sat;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `DHG_ASSERT_ALWAYS(a_lobes_aligned, i_clk, i_rst_n, s_lv_a == s_lv_b, "lobe pipelines out of step")
    `DHG_ASSERT_IMPLY(a_cos_range, i_clk, i_rst_n, r_v_c2, (r_c2 <= 16'sd16384) && (r_c2 >= -16'sd16384), "cosine out of range")
    `DHG_ASSERT_IMPLY(a_sat_max, i_clk, i_rst_n, o_res_valid && o_res.saturated, o_res.phase_value == 32'hFFFFFFFF, "saturated value not at maximum")

endmodule

// ----- tb/sv/double_henyey_greenstein_phase_test.sv -----
module double_henyey_greenstein_phase_test
    import dhg_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = longint'(1) << IN_FRAC_BITS;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        bit          set_cfg;
        logic [15:0] asym_a;
        logic [15:0] asym_b;
        logic [15:0] weight;
        t_dir_in     dirs;
        bit          typed;
        logic [31:0] phase;
        bit          sat;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_dir_in     i_data;
    logic        o_res_valid;
    t_phase_out  o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    logic [15:0] asym_a_reg;
    logic [15:0] asym_b_reg;
    logic [14:0] weight_reg;

    t_phase_out pending_phase[$];
    t_phase_out typed_phase[$];
    bit         typed_flag[$];
    int         errors;
    int         cycles;
    bit         no_gaps;
    t_row       rows[$];

    double_henyey_greenstein_phase dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_data      (i_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // one lobe in units of 2^-OUT_FRAC_BITS
    function automatic logic [63:0] lobe_units(longint g, longint c);
        longint      n;
        longint      d;
        int          e;
        int          len;
        int          sh;
        logic [63:0] ud;
        logic [63:0] dn;
        logic [63:0] sn;
        logic [63:0] dv;
        logic [63:0] q;
        logic [127:0] p;
        if (g > ONE) g = ONE;
        if (g < -ONE) g = -ONE;
        n = ONE * ONE - g * g;
        if (n <= 0) return 64'd0;
        d = ONE * ONE + g * g - 2 * g * c;
        if (d <= 0) return '1;
        ud = d;
        len = 0;
        while (len < 64 && (ud >> len) != 0) len++;
        sh = 32 - len;
        if (len % 2 == 1) sh--;
        dn = (sh >= 0) ? (ud << sh) : (ud >> (-sh));
        sn = int_sqrt(dn << 30);
        e = E_BIAS + (3 * sh) / 2;
        p = {64'd0, 64'(n)} * {99'd0, INV_FOUR_PI_Q32};
        for (int i = 0; i < e; i++) begin
            if (p[127]) return '1;
            p = p << 1;
        end
        dv = dn * sn;
        if (p[127:64] >= dv) q = '1;
        else q = 64'(p / {64'd0, dv});
        if (e < 0) q = (-e < 64) ? (q >> (-e)) : 64'd0;
        return q;
    endfunction

    function automatic t_phase_out phase_of(t_dir_in v);
        longint      dot;
        longint      c;
        longint      w;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [127:0] acc;
        t_phase_out  r;
        dot = longint'(v.incoming_x) * longint'(v.outgoing_x)
            + longint'(v.incoming_y) * longint'(v.outgoing_y)
            + longint'(v.incoming_z) * longint'(v.outgoing_z);
        if (dot > ONE * ONE) dot = ONE * ONE;
        if (dot < -ONE * ONE) dot = -ONE * ONE;
        c = ((dot + ONE * ONE + ONE / 2) >>> IN_FRAC_BITS) - ONE;
        p1 = lobe_units(longint'($signed(asym_a_reg)), c);
        p2 = lobe_units(longint'($signed(asym_b_reg)), c);
        w = weight_reg;
        if (w > ONE) w = ONE;
        acc = {64'd0, p1} * 128'(w) + {64'd0, p2} * 128'(ONE - w) + 128'(ONE / 2);
        acc = acc >> IN_FRAC_BITS;
        if (acc[127:32] != 0) begin
            r.phase_value = '1;
            r.saturated = 1'b1;
        end else begin
            r.phase_value = acc[31:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_phase_out want;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("double_henyey_greenstein_phase regression: fail");
            $finish;
        end
        if (i_rst_n && o_res_valid) begin
            if (pending_phase.size() == 0) begin
                $display("%0t: unexpected result phase=%h sat=%b",
                         $time, o_res.phase_value, o_res.saturated);
                errors++;
            end else begin
                want = pending_phase.pop_front();
                if (o_res.phase_value !== want.phase_value) begin
                    $display("%0t: phase_value expected %h actual %h",
                             $time, want.phase_value, o_res.phase_value);
                    errors++;
                end
                if (o_res.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, o_res.saturated);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_start && !o_busy) begin
            want = phase_of(i_data);
            if (typed_flag.pop_front()) begin
                if (typed_phase[0] !== want) begin
                    $display("%0t: predictor expected %h/%b computed %h/%b", $time,
                             typed_phase[0].phase_value, typed_phase[0].saturated,
                             want.phase_value, want.saturated);
                    errors++;
                end
                want = typed_phase[0];
            end
            void'(typed_phase.pop_front());
            pending_phase = {pending_phase, want};
        end
    end

    task automatic gap();
        while (!no_gaps && $urandom_range(99) < 11) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send(t_dir_in v, bit typed, t_phase_out want);
        bit held;
        gap();
        typed_flag = {typed_flag, typed};
        typed_phase = {typed_phase, want};
        i_start = 1'b1;
        i_data = v;
        do begin
            held = o_busy;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (held);
        i_start = 1'b0;
    endtask

    task automatic drain();
        while (pending_phase.size() != 0 || typed_flag.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        bit rdy;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do begin
            rdy = o_cfg_ready;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (!rdy);
        i_cfg_valid = 1'b0;
        case (idx)
            CFG_LOBE_A_ASYM: asym_a_reg = val;
            CFG_LOBE_B_ASYM: asym_b_reg = val;
            CFG_LOBE_A_WEIGHT: weight_reg = val[14:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] ga, logic [15:0] gb, logic [15:0] wt);
        drain();
        write_reg(CFG_LOBE_A_ASYM, ga);
        write_reg(CFG_LOBE_B_ASYM, gb);
        write_reg(CFG_LOBE_A_WEIGHT, wt);
        write_reg(2'd3, 16'($urandom));
    endtask

    function automatic t_dir_in dirs(int ix, int iy, int iz, int ox, int oy, int oz);
        t_dir_in v;
        v.incoming_x = 16'(ix);
        v.incoming_y = 16'(iy);
        v.incoming_z = 16'(iz);
        v.outgoing_x = 16'(ox);
        v.outgoing_y = 16'(oy);
        v.outgoing_z = 16'(oz);
        return v;
    endfunction

    function automatic logic [15:0] rand_asym();
        case ($urandom_range(7))
            0: return 16'(16384);
            1: return 16'(-16384);
            2: return 16'($urandom);
            3: return 16'(0);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(32768)) - 16384);
            default: return 16'($urandom_range(2) * 16384 - 16384);
        endcase
    endfunction

    function automatic void add(bit cfg, int ga, int gb, int wt, t_dir_in v,
                                bit typed, logic [31:0] ph, bit s);
        t_row r;
        r.set_cfg = cfg;
        r.asym_a = 16'(ga);
        r.asym_b = 16'(gb);
        r.weight = 16'(wt);
        r.dirs = v;
        r.typed = typed;
        r.phase = ph;
        r.sat = s;
        rows = {rows, r};
    endfunction

    initial begin
        t_phase_out want;
        t_dir_in    v;
        int         mode;
        errors = 0;
        cycles = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LOBE_A_ASYM;
        i_cfg_data = '0;
        asym_a_reg = 16'd0;
        asym_b_reg = 16'd0;
        weight_reg = 15'd16384;

        // isotropic lobes after reset give 1/(4 pi)
        add(0, 0, 0, 0, dirs(0, 0, 0, 0, 0, 0), 1, 32'd83443, 0);
        add(0, 0, 0, 0, dirs(16384, 16384, 16384, 16384, 16384, 16384), 1, 32'd83443, 0);
        add(0, 0, 0, 0, dirs(-32768, -32768, -32768, 32767, 32767, 32767),
            1, 32'd83443, 0);
        add(0, 0, 0, 0, dirs(32767, -32768, 32767, -32768, 32767, -32768),
            1, 32'd83443, 0);
        // both lobes at a pole
        add(1, 16384, -16384, 5000, dirs(16384, 0, 0, 16384, 0, 0), 1, 32'd0, 0);
        add(0, 0, 0, 0, dirs(16384, 0, 0, -16384, 0, 0), 1, 32'd0, 0);
        add(0, 0, 0, 0, dirs(0, 16384, 0, 16384, 0, 0), 1, 32'd0, 0);
        // asymmetry beyond one clamps to a pole
        add(1, 32767, -32768, 32767, dirs(0, 0, 16384, 0, 0, 16384), 1, 32'd0, 0);
        add(0, 0, 0, 0, dirs(-32768, 0, 0, 32767, 0, 0), 1, 32'd0, 0);
        // sharp forward lobe saturates, weight beyond one
        add(1, 16383, 0, 32767, dirs(16384, 0, 0, 16384, 0, 0), 0, 0, 0);
        add(0, 0, 0, 0, dirs(16384, 0, 0, -16384, 0, 0), 0, 0, 0);
        add(0, 0, 0, 0, dirs(0, 0, 16384, 0, 11585, 11585), 0, 0, 0);
        add(1, -16383, 16383, 0, dirs(16384, 0, 0, -16384, 0, 0), 0, 0, 0);
        add(0, 0, 0, 0, dirs(16384, 0, 0, 16384, 0, 0), 0, 0, 0);
        add(1, 8192, -8192, 8192, dirs(11585, 11585, 0, 0, 11585, 11585), 0, 0, 0);
        add(0, 0, 0, 0, dirs(0, 0, 0, 0, 0, 0), 0, 0, 0);
        add(0, 0, 0, 0, dirs(1, -1, 1, -1, 1, -1), 0, 0, 0);
        add(1, 12000, -3000, 1, dirs(16384, 0, 0, 0, 16384, 0), 0, 0, 0);
        add(0, 0, 0, 0, dirs(9459, 9459, 9459, -9459, 9459, -9459), 0, 0, 0);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].set_cfg) configure(rows[k].asym_a, rows[k].asym_b, rows[k].weight);
            want.phase_value = rows[k].phase;
            want.saturated = rows[k].sat;
            send(rows[k].dirs, rows[k].typed, want);
        end

        for (int ph = 0; ph < 8; ph++) begin
            no_gaps = (ph == 3);
            case (ph)
                0: configure(16'(-16384), 16'(16384), 16'd0);
                1: configure(16'(16384), 16'(-16384), 16'd16384);
                default: configure(rand_asym(), rand_asym(),
                                   ($urandom_range(3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(16384)));
            endcase
            for (int k = 0; k < 230; k++) begin
                mode = $urandom_range(2);
                v.incoming_x = rand_comp(mode);
                v.incoming_y = rand_comp(mode);
                v.incoming_z = rand_comp(mode);
                v.outgoing_x = rand_comp(mode);
                v.outgoing_y = rand_comp(mode);
                v.outgoing_z = rand_comp(mode);
                send(v, 1'b0, want);
            end
        end

        drain();
        if (errors == 0) begin
            $display("double_henyey_greenstein_phase regression: pass");
        end else begin
            $display("double_henyey_greenstein_phase regression: fail");
        end
        $finish;
    end
endmodule
